// ----- hw/rtl/perspective_triangle_edges_defines.svh -----
// Assertion macros used by the perspective triangle edge back end.
`ifndef PERSPECTIVE_TRIANGLE_EDGES_DEFINES_SVH
`define PERSPECTIVE_TRIANGLE_EDGES_DEFINES_SVH

// Implication checked every cycle outside reset.
`define PTE_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// Implication checked in the cycle after the antecedent.
`define PTE_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/pte_pkg.sv -----
// Types and constants for the perspective triangle edge block.
package pte_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned DIFF_W  = 33;
  localparam int unsigned TRIG_W  = 16;
  localparam int unsigned NEAR_W  = 31;
  localparam int unsigned VIEWP_W = 14;
  localparam int unsigned PROD_W  = 49;
  localparam int unsigned VIEW_W  = 50;
  localparam int unsigned MP_W    = 65;
  localparam int unsigned NUM_W   = 66;
  localparam int unsigned DEN_W   = 52;
  localparam int unsigned SCR_W   = 16;
  localparam int unsigned FOCAL_W = 14;
  localparam int unsigned IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CAMERA_X  = 3'd0,
    REG_CAMERA_Y  = 3'd1,
    REG_CAMERA_Z  = 3'd2,
    REG_COS_YAW   = 3'd3,
    REG_SIN_YAW   = 3'd4,
    REG_NEAR      = 3'd5,
    REG_VP_WIDTH  = 3'd6,
    REG_VP_HEIGHT = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    EDGE_AB = 2'd0,
    EDGE_BC = 2'd1,
    EDGE_CA = 2'd2,
    EDGE_NONE = 2'd3
  } edge_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
    logic final_tri;
  } tri_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] camera_x;
    logic signed [COORD_W-1:0] camera_y;
    logic signed [COORD_W-1:0] camera_z;
    logic signed [TRIG_W-1:0]  cos_yaw;
    logic signed [TRIG_W-1:0]  sin_yaw;
    logic [NEAR_W-1:0]         near_plane;
    logic [VIEWP_W-1:0]        vp_width;
    logic [VIEWP_W-1:0]        vp_height;
  } cfg_t;

  typedef struct packed {
    logic                    vis;
    logic signed [SCR_W-1:0] sx;
    logic signed [SCR_W-1:0] sy;
  } vres_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] start_x;
    logic signed [SCR_W-1:0] start_y;
    logic signed [SCR_W-1:0] end_x;
    logic signed [SCR_W-1:0] end_y;
    logic                    drawn;
    logic [1:0]              edge_index;
    logic                    last_edge;
    logic                    mesh_done;
  } edge_t;

endpackage

// ----- hw/rtl/pte_front.sv -----
// Front end: triangle intake into a two-entry queue.
module pte_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  pte_pkg::tri_t in_tri_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output pte_pkg::tri_t q_tri_o
);
  import pte_pkg::*;

  tri_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  logic       push;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_tri_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_tri_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (q_pop_i && q_valid_o) rptr_q <= ~rptr_q;
      unique case ({push, q_pop_i && q_valid_o})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hw/rtl/pte_div.sv -----
// Restoring divider: saturated 16-bit truncated quotient of signed by positive.
module pte_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [pte_pkg::NUM_W-1:0]  num_i,
  input  logic [pte_pkg::DEN_W-1:0]         den_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic signed [pte_pkg::SCR_W-1:0]  quo_o
);
  import pte_pkg::*;

  localparam int unsigned R_W   = 70;
  localparam int unsigned Q_W   = SCR_W + 1;

  logic [R_W-1:0]   r_q, dsh_q;
  logic [Q_W-1:0]   q_q;
  logic [4:0]       cnt_q;
  logic             neg_q, ovf_q, busy_q, done_q;
  logic [NUM_W-1:0] mag;
  logic [R_W-1:0]   den_ext;
  logic             ge;

  assign mag     = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign den_ext = R_W'(den_i);
  assign ge      = (r_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(SCR_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= R_W'(mag);
      dsh_q <= den_ext << SCR_W;
      q_q   <= '0;
      neg_q <= num_i[NUM_W-1];
      ovf_q <= (R_W'(mag) >= (den_ext << Q_W));
    end else if (busy_q) begin
      if (ge) r_q <= r_q - dsh_q;
      q_q   <= {q_q[Q_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  // negative side reaches -32768 exactly; anything beyond saturates
  always_comb begin
    if (neg_q) begin
      quo_o = (ovf_q || q_q[Q_W-1] || (q_q[SCR_W-1] && (|q_q[SCR_W-2:0])))
              ? {1'b1, {(SCR_W-1){1'b0}}} : SCR_W'(-q_q[SCR_W-1:0]);
    end else begin
      quo_o = (ovf_q || q_q[Q_W-1] || q_q[SCR_W-1]) ? {1'b0, {(SCR_W-1){1'b1}}}
                                                    : q_q[SCR_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// ----- hw/rtl/pte_back.sv -----
// Back end: per-vertex projection sequencer and edge output register.
`include "perspective_triangle_edges_defines.svh"
module pte_back #(
  parameter int unsigned FOCAL_DIST = 730
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pte_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  pte_pkg::tri_t  q_tri_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pte_pkg::edge_t out_edge_o
);
  import pte_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SUB, S_MUL1, S_SUM, S_MUL2, S_NUM, S_DIV, S_EMIT
  } state_e;

  state_e state_q;
  tri_t   tri_q;
  logic [1:0] vidx_q;
  edge_e  edge_q;

  logic signed [DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic signed [PROD_W-1:0] p_cx_q, p_sz_q, p_cz_q, p_sx_q;
  logic signed [VIEW_W-1:0] xr_q, yr_q, d_q;
  logic                     vis_q;
  logic signed [MP_W-1:0]   fx_q, wd_q, fy_q, hd_q;
  vres_t va_q, vb_q, vc_q;
  logic  out_valid_q;
  edge_t out_q;

  vtx_t vsel;
  logic signed [FOCAL_W-1:0] focal;
  logic signed [VIEW_W-1:0]  z_sum, near_v;
  logic signed [NUM_W-1:0]   num_x, num_y;
  logic [DEN_W-1:0]          den;
  logic div_start, bx, by, dnx, dny;
  logic signed [SCR_W-1:0]   qx, qy;
  vres_t vres, e_s, e_e;
  logic  load;

  assign focal  = FOCAL_W'(FOCAL_DIST);
  assign z_sum  = VIEW_W'(p_cz_q) + VIEW_W'(p_sx_q);
  assign near_v = $signed({{(VIEW_W-NEAR_W-14){1'b0}}, cfg_i.near_plane, 14'b0});
  assign num_x  = NUM_W'(fx_q) + NUM_W'(wd_q);
  assign num_y  = NUM_W'(hd_q) - NUM_W'(fy_q);
  assign den    = DEN_W'({d_q, 1'b0});
  assign div_start = (state_q == S_NUM);
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign load    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    unique case (vidx_q)
      2'd0:    vsel = tri_q.a;
      2'd1:    vsel = tri_q.b;
      default: vsel = tri_q.c;
    endcase
  end

  assign vres = '{vis: vis_q, sx: qx, sy: qy};

  always_comb begin
    unique case (edge_q)
      EDGE_AB: begin e_s = va_q; e_e = vb_q; end
      EDGE_BC: begin e_s = vb_q; e_e = vc_q; end
      default: begin e_s = vc_q; e_e = va_q; end
    endcase
  end

  pte_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_x), .den_i(den),
    .busy_o(bx), .done_o(dnx), .quo_o(qx)
  );

  pte_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num_y), .den_i(den),
    .busy_o(by), .done_o(dny), .quo_o(qy)
  );

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) tri_q <= q_tri_i;
    if (state_q == S_SUB) begin
      dx_q <= DIFF_W'(vsel.x) - DIFF_W'(cfg_i.camera_x);
      dy_q <= DIFF_W'(vsel.y) - DIFF_W'(cfg_i.camera_y);
      dz_q <= DIFF_W'(vsel.z) - DIFF_W'(cfg_i.camera_z);
    end
    if (state_q == S_MUL1) begin
      p_cx_q <= PROD_W'(cfg_i.cos_yaw * dx_q);
      p_sz_q <= PROD_W'(cfg_i.sin_yaw * dz_q);
      p_cz_q <= PROD_W'(cfg_i.cos_yaw * dz_q);
      p_sx_q <= PROD_W'(cfg_i.sin_yaw * dx_q);
    end
    if (state_q == S_SUM) begin
      xr_q  <= VIEW_W'(p_cx_q) - VIEW_W'(p_sz_q);
      yr_q  <= VIEW_W'(dy_q) <<< 14;
      d_q   <= -z_sum;
      vis_q <= !((-z_sum) < near_v) && ((-z_sum) > $signed(VIEW_W'(0)));
    end
    if (state_q == S_MUL2) begin
      fx_q <= MP_W'(focal * xr_q);
      fy_q <= MP_W'(focal * yr_q);
      wd_q <= MP_W'($signed({1'b0, cfg_i.vp_width}) * d_q);
      hd_q <= MP_W'($signed({1'b0, cfg_i.vp_height}) * d_q);
    end
    if ((state_q == S_DIV) && dnx && dny) begin
      unique case (vidx_q)
        2'd0:    va_q <= vres;
        2'd1:    vb_q <= vres;
        default: vc_q <= vres;
      endcase
    end
    if (load) begin
      out_q.drawn      <= e_s.vis && e_e.vis;
      out_q.start_x    <= (e_s.vis && e_e.vis) ? e_s.sx : '0;
      out_q.start_y    <= (e_s.vis && e_e.vis) ? e_s.sy : '0;
      out_q.end_x      <= (e_s.vis && e_e.vis) ? e_e.sx : '0;
      out_q.end_y      <= (e_s.vis && e_e.vis) ? e_e.sy : '0;
      out_q.edge_index <= edge_q;
      out_q.last_edge  <= (edge_q == EDGE_CA);
      out_q.mesh_done  <= (edge_q == EDGE_CA) && tri_q.final_tri;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vidx_q      <= 2'd0;
      edge_q      <= EDGE_AB;
      out_valid_q <= 1'b0;
    end else begin
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_valid_i) begin
          state_q <= S_SUB;
          vidx_q  <= 2'd0;
        end
        S_SUB:  state_q <= S_MUL1;
        S_MUL1: state_q <= S_SUM;
        S_SUM:  state_q <= S_MUL2;
        S_MUL2: state_q <= S_NUM;
        S_NUM:  state_q <= S_DIV;
        S_DIV: if (dnx && dny) begin
          if (vidx_q == 2'd2) begin
            state_q <= S_EMIT;
            edge_q  <= EDGE_AB;
          end else begin
            vidx_q  <= vidx_q + 2'd1;
            state_q <= S_SUB;
          end
        end
        S_EMIT: if (load) begin
          if (edge_q == EDGE_CA) state_q <= S_IDLE;
          else edge_q <= edge_e'(edge_q + 2'd1);
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_edge_o  = out_q;

  `PTE_ASSERT_IMP(a_div_in_div_state, bx || by, state_q == S_DIV, "divider busy outside wait")
  `PTE_ASSERT_IMP(a_done_last, out_valid_q && out_q.mesh_done, out_q.last_edge, "mesh_done off last edge")
  `PTE_ASSERT_NXT(a_emit_end, load && (edge_q == EDGE_CA), state_q == S_IDLE, "emit did not end")

endmodule

// ----- hw/rtl/perspective_triangle_edges.sv -----
// Top level of the perspective triangle edge projector.
//
//  channel | direction | handshake            | word
//  in      | sink      | in_valid_i/in_ready_o   | one triangle (a, b, c, final)
//  out     | source    | out_valid_o/out_ready_i | one screen edge
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | register index and data
//
// In the back end each triangle is popped from the queue; then its three vertices
// are projected in turn, each by five datapath steps, 17 steps of the per-axis
// restoring divider and a done strobe; then the edges a-b, b-c, c-a are emitted.
// The divider does most of the work per vertex.
// A two-entry queue takes new triangles meanwhile.
// Reset restores register defaults and empties the queue; no clearing pass.
// Output stalls hold the edge register and, through the queue, the intake.
module perspective_triangle_edges #(
  parameter int unsigned FOCAL_DIST = 730
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_a_x_i,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_a_y_i,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_a_z_i,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_b_x_i,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_b_y_i,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_b_z_i,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_c_x_i,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_c_y_i,
  input  logic signed [pte_pkg::COORD_W-1:0]  vertex_c_z_i,
  input  logic                                final_triangle_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pte_pkg::SCR_W-1:0]    start_x_o,
  output logic signed [pte_pkg::SCR_W-1:0]    start_y_o,
  output logic signed [pte_pkg::SCR_W-1:0]    end_x_o,
  output logic signed [pte_pkg::SCR_W-1:0]    end_y_o,
  output logic                                drawn_o,
  output logic [1:0]                          edge_index_o,
  output logic                                last_edge_o,
  output logic                                mesh_done_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pte_pkg::IDX_W-1:0]           cfg_index_i,
  input  logic [pte_pkg::COORD_W-1:0]         cfg_data_i
);
  import pte_pkg::*;

  cfg_t  cfg_q;
  tri_t  in_tri, q_tri;
  logic  q_valid, q_pop;
  edge_t edge_w;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.camera_x   <= '0;
      cfg_q.camera_y   <= '0;
      cfg_q.camera_z   <= '0;
      cfg_q.cos_yaw    <= 16'sd16384;
      cfg_q.sin_yaw    <= '0;
      cfg_q.near_plane <= 31'd9830;
      cfg_q.vp_width   <= 14'd640;
      cfg_q.vp_height  <= 14'd480;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_CAMERA_X:  cfg_q.camera_x   <= cfg_data_i;
        REG_CAMERA_Y:  cfg_q.camera_y   <= cfg_data_i;
        REG_CAMERA_Z:  cfg_q.camera_z   <= cfg_data_i;
        REG_COS_YAW:   cfg_q.cos_yaw    <= cfg_data_i[TRIG_W-1:0];
        REG_SIN_YAW:   cfg_q.sin_yaw    <= cfg_data_i[TRIG_W-1:0];
        REG_NEAR:      cfg_q.near_plane <= cfg_data_i[NEAR_W-1:0];
        REG_VP_WIDTH:  cfg_q.vp_width   <= cfg_data_i[VIEWP_W-1:0];
        REG_VP_HEIGHT: cfg_q.vp_height  <= cfg_data_i[VIEWP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tri.a.x = vertex_a_x_i;
  assign in_tri.a.y = vertex_a_y_i;
  assign in_tri.a.z = vertex_a_z_i;
  assign in_tri.b.x = vertex_b_x_i;
  assign in_tri.b.y = vertex_b_y_i;
  assign in_tri.b.z = vertex_b_z_i;
  assign in_tri.c.x = vertex_c_x_i;
  assign in_tri.c.y = vertex_c_y_i;
  assign in_tri.c.z = vertex_c_z_i;
  assign in_tri.final_tri = final_triangle_i;

  pte_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .in_tri_i(in_tri),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_tri_o(q_tri)
  );

  pte_back #(.FOCAL_DIST(FOCAL_DIST)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_tri_i(q_tri),
    .out_valid_o, .out_ready_i, .out_edge_o(edge_w)
  );

  assign start_x_o    = edge_w.start_x;
  assign start_y_o    = edge_w.start_y;
  assign end_x_o      = edge_w.end_x;
  assign end_y_o      = edge_w.end_y;
  assign drawn_o      = edge_w.drawn;
  assign edge_index_o = edge_w.edge_index;
  assign last_edge_o  = edge_w.last_edge;
  assign mesh_done_o  = edge_w.mesh_done;

endmodule
